>>> rtl/pcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcf_pkg: shared types and constants of the playout control block
// States, request codes, register map, matrix move records and helpers.
// ----------------------------------------------------------------------------
package pcf_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int STATE_COUNT     = 7;
    localparam int CELL_COUNT      = STATE_COUNT * STATE_COUNT;
    localparam int CELL_IDX_W      = $clog2(CELL_COUNT);
    localparam int MOVE_SLOTS      = 3;
    localparam int EVENT_COUNT     = 6;
    localparam int APB_ADDR_W      = 5;
    localparam int TIME_W          = 62;

    localparam int CNT_ILLEGAL  = 0;
    localparam int CNT_LATENCY  = 1;
    localparam int CNT_TIMEOUT  = 2;
    localparam int CNT_OVERFLOW = 3;
    localparam int CNT_RECOVER  = 4;
    localparam int CNT_LATESEEK = 5;

    localparam logic [31:0] LIMIT_RESET     = 32'd500000;
    localparam logic [15:0] READINESS_RESET = 16'd3;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_BUFFERING = 3'd1,
        ST_READY     = 3'd2,
        ST_PLAYING   = 3'd3,
        ST_PAUSED    = 3'd4,
        ST_STOPPING  = 3'd5,
        ST_ERROR     = 3'd6
    } state_t;

    typedef enum logic [3:0] {
        REQ_BEGIN    = 4'd0,
        REQ_PAUSE    = 4'd1,
        REQ_RESUME   = 4'd2,
        REQ_SEEK     = 4'd3,
        REQ_STOP     = 4'd4,
        REQ_RECOVER  = 4'd5,
        REQ_DEPTH    = 4'd6,
        REQ_UNDERRUN = 4'd7,
        REQ_OVERRUN  = 4'd8,
        REQ_CLEARED  = 4'd9,
        REQ_TIMEOUT  = 4'd10,
        REQ_OVERFLOW = 4'd11,
        REQ_QUERY    = 4'd12
    } req_t;

    typedef enum logic [2:0] {
        REG_PAUSE_LIMIT  = 3'd0,
        REG_RESUME_LIMIT = 3'd1,
        REG_SEEK_LIMIT   = 3'd2,
        REG_STOP_LIMIT   = 3'd3,
        REG_READINESS    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] pause_limit;
        logic [31:0] resume_limit;
        logic [31:0] seek_limit;
        logic [31:0] stop_limit;
        logic [15:0] readiness;
    } cfg_t;

    typedef struct packed {
        logic   valid;
        state_t from;
        state_t to;
    } move_t;

    typedef move_t [MOVE_SLOTS-1:0] move_list_t;

    function automatic logic [CELL_IDX_W-1:0] cell_index(input logic [2:0] from,
                                                         input logic [2:0] to);
        cell_index = CELL_IDX_W'(from) * CELL_IDX_W'(STATE_COUNT) + CELL_IDX_W'(to);
    endfunction

endpackage
`default_nettype wire

>>> rtl/pcf_sat_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcf_sat_counter: saturating event counter
// Counts up on inc, holds at all ones; shows the count clamped to 32 bits.
// ----------------------------------------------------------------------------
module pcf_sat_counter #(
    parameter int WIDTH = pcf_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        inc,
    output logic [31:0]      view
);

    logic [WIDTH-1:0] count_reg;
    logic [WIDTH-1:0] count_next;

    always_comb begin
        count_next = count_reg;
        if (inc && (count_reg != {WIDTH{1'b1}})) begin
            count_next = count_reg + WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    generate
        if (WIDTH > 32) begin : g_wide
            assign view = (|count_reg[WIDTH-1:32]) ? 32'hFFFF_FFFF : count_reg[31:0];
        end else if (WIDTH == 32) begin : g_exact
            assign view = count_reg;
        end else begin : g_narrow
            assign view = {{(32-WIDTH){1'b0}}, count_reg};
        end
    endgenerate

endmodule
`default_nettype wire

>>> rtl/pcf_trans_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcf_trans_matrix: 7x7 state-change count matrix
// One saturating cell per state pair, bumped by the move list of a beat,
// with a read port for the queried pair.
// ----------------------------------------------------------------------------
module pcf_trans_matrix #(
    parameter int COUNT_WIDTH = pcf_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pcf_pkg::move_list_t  moves,
    input  wire logic [2:0]           query_from,
    input  wire logic [2:0]           query_to,
    output logic [31:0]               query_view
);

    logic [31:0] cell_view [pcf_pkg::CELL_COUNT];

    genvar gi, gj;
    generate
        for (gi = 0; gi < pcf_pkg::STATE_COUNT; gi++) begin : g_row
            for (gj = 0; gj < pcf_pkg::STATE_COUNT; gj++) begin : g_col
                logic hit;

                always_comb begin
                    hit = 1'b0;
                    for (int k = 0; k < pcf_pkg::MOVE_SLOTS; k++) begin
                        if (moves[k].valid && (moves[k].from == 3'(gi))
                            && (moves[k].to == 3'(gj))) begin
                            hit = 1'b1;
                        end
                    end
                end

                pcf_sat_counter #(
                    .WIDTH (COUNT_WIDTH)
                ) u_cell (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .inc     (hit),
                    .view    (cell_view[gi*pcf_pkg::STATE_COUNT + gj])
                );
            end
        end
    endgenerate

    assign query_view = cell_view[pcf_pkg::cell_index(query_from, query_to)];

endmodule
`default_nettype wire

>>> rtl/pcf_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcf_apb_regs: configuration register file
// Latency limits and readiness threshold, written and read over APB.
// ----------------------------------------------------------------------------
module pcf_apb_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pcf_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output pcf_pkg::cfg_t                      cfg
);

    pcf_pkg::cfg_t     cfg_reg;
    pcf_pkg::cfg_t     cfg_next;
    pcf_pkg::reg_idx_t reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = pcf_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                pcf_pkg::REG_PAUSE_LIMIT:  cfg_next.pause_limit  = pwdata;
                pcf_pkg::REG_RESUME_LIMIT: cfg_next.resume_limit = pwdata;
                pcf_pkg::REG_SEEK_LIMIT:   cfg_next.seek_limit   = pwdata;
                pcf_pkg::REG_STOP_LIMIT:   cfg_next.stop_limit   = pwdata;
                pcf_pkg::REG_READINESS:    cfg_next.readiness    = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pcf_pkg::REG_PAUSE_LIMIT:  prdata = cfg_reg.pause_limit;
            pcf_pkg::REG_RESUME_LIMIT: prdata = cfg_reg.resume_limit;
            pcf_pkg::REG_SEEK_LIMIT:   prdata = cfg_reg.seek_limit;
            pcf_pkg::REG_STOP_LIMIT:   prdata = cfg_reg.stop_limit;
            pcf_pkg::REG_READINESS:    prdata = {16'b0, cfg_reg.readiness};
            default:                   prdata = 32'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pause_limit  <= pcf_pkg::LIMIT_RESET;
            cfg_reg.resume_limit <= pcf_pkg::LIMIT_RESET;
            cfg_reg.seek_limit   <= pcf_pkg::LIMIT_RESET;
            cfg_reg.stop_limit   <= pcf_pkg::LIMIT_RESET;
            cfg_reg.readiness    <= pcf_pkg::READINESS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

>>> rtl/playout_control_fsm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// playout_control_fsm: playback control state machine
// Takes one command or event beat per cycle unless m_tready stalls the
// result, and returns one result beat per beat; the beat sits in the input
// register, its result in the output register. The play state, position,
// six event counters and the 7x7 state-change matrix update as the result
// is registered, so throughput is one beat per clock when unstalled. The
// result beat shows the counters, play state and position after its beat;
// they hold while it waits on m_tready. After reset all counters and matrix
// cells read zero at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module playout_control_fsm #(
    parameter int COUNT_WIDTH = pcf_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: request_time[61:0], effective_time[123:62], seek_target[185:124],
    //          buffer_depth[201:186], buffer_capacity[217:202],
    //          query_from[220:218], query_to[223:221]
    input  wire logic [223:0]                   s_tdata,
    // s_tuser: req_type[3:0], cmd_repeat[4]
    input  wire logic [4:0]                     s_tuser,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // m_tdata: accepted[0], play_state[3:1], illegal_count[35:4],
    //          slow_cmd_count[67:36], timeout_count[99:68],
    //          overflow_count[131:100], recovery_count[163:132],
    //          behind_seek_count[195:164], position[257:196],
    //          transition_count[289:258], zero pad[295:290]
    output logic [295:0]                        m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pcf_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int TW = pcf_pkg::TIME_W;

    pcf_pkg::cfg_t cfg;

    // input register
    logic          in_valid_reg, in_valid_next;
    logic [3:0]    in_type_reg;
    logic          in_repeat_reg;
    logic [TW-1:0] in_req_reg, in_eff_reg, in_target_reg;
    logic [15:0]   in_depth_reg, in_cap_reg;
    logic [2:0]    in_qf_reg, in_qt_reg;

    // state and result
    pcf_pkg::state_t mode_reg, mode_next;
    logic [TW-1:0]   pos_reg, pos_next;
    logic            out_valid_reg, out_valid_next;
    logic            acc_reg, acc_next;
    logic [31:0]     tcount_reg, tcount_next;

    logic                                   out_free, fire, in_take;
    pcf_pkg::move_list_t                    moves;
    logic [pcf_pkg::EVENT_COUNT-1:0]        ev_inc;
    logic [31:0]                            ev_view [pcf_pkg::EVENT_COUNT];
    logic [31:0]                            query_view;
    logic                                   lat_en;
    logic [31:0]                            lat_limit;
    logic [TW-1:0]                          lat_diff;
    logic                                   lat_over;
    logic                                   is_command;
    pcf_pkg::req_t                          req;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    pcf_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_type_reg   <= s_tuser[3:0];
            in_repeat_reg <= s_tuser[4];
            in_req_reg    <= s_tdata[61:0];
            in_eff_reg    <= s_tdata[123:62];
            in_target_reg <= s_tdata[185:124];
            in_depth_reg  <= s_tdata[201:186];
            in_cap_reg    <= s_tdata[217:202];
            in_qf_reg     <= s_tdata[220:218];
            in_qt_reg     <= s_tdata[223:221];
        end
    end

    assign req        = pcf_pkg::req_t'(in_type_reg);
    assign is_command = (in_type_reg <= 4'(pcf_pkg::REQ_RECOVER));

    assign lat_diff = in_eff_reg - in_req_reg;

    // next state, moves and counter events for the beat in the input register
    always_comb begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        acc_next    = 1'b1;
        tcount_next = 32'b0;
        moves       = '0;
        ev_inc      = '0;
        lat_en      = 1'b0;
        lat_limit   = 32'b0;

        if (!(is_command && in_repeat_reg)) begin
            unique case (req)
                pcf_pkg::REQ_BEGIN: begin
                    if (mode_reg != pcf_pkg::ST_IDLE) begin
                        ev_inc[pcf_pkg::CNT_ILLEGAL] = 1'b1;
                        moves[0] = '{1'b1, mode_reg, pcf_pkg::ST_BUFFERING};
                        acc_next = 1'b0;
                    end else begin
                        moves[0]  = '{1'b1, mode_reg, pcf_pkg::ST_BUFFERING};
                        mode_next = pcf_pkg::ST_BUFFERING;
                    end
                end
                pcf_pkg::REQ_PAUSE: begin
                    moves[0] = '{1'b1, mode_reg, pcf_pkg::ST_PAUSED};
                    if (mode_reg != pcf_pkg::ST_PLAYING) begin
                        ev_inc[pcf_pkg::CNT_ILLEGAL] = 1'b1;
                        acc_next = 1'b0;
                    end else begin
                        lat_en    = 1'b1;
                        lat_limit = cfg.pause_limit;
                        mode_next = pcf_pkg::ST_PAUSED;
                    end
                end
                pcf_pkg::REQ_RESUME: begin
                    moves[0] = '{1'b1, mode_reg, pcf_pkg::ST_PLAYING};
                    if (mode_reg != pcf_pkg::ST_PAUSED) begin
                        ev_inc[pcf_pkg::CNT_ILLEGAL] = 1'b1;
                        acc_next = 1'b0;
                    end else begin
                        lat_en    = 1'b1;
                        lat_limit = cfg.resume_limit;
                        mode_next = pcf_pkg::ST_PLAYING;
                    end
                end
                pcf_pkg::REQ_SEEK: begin
                    if (in_target_reg < pos_reg) begin
                        ev_inc[pcf_pkg::CNT_LATESEEK] = 1'b1;
                        acc_next = 1'b0;
                    end else if ((mode_reg != pcf_pkg::ST_PLAYING)
                                 && (mode_reg != pcf_pkg::ST_PAUSED)) begin
                        ev_inc[pcf_pkg::CNT_ILLEGAL] = 1'b1;
                        moves[0] = '{1'b1, mode_reg, pcf_pkg::ST_BUFFERING};
                        acc_next = 1'b0;
                    end else begin
                        lat_en    = 1'b1;
                        lat_limit = cfg.seek_limit;
                        moves[0]  = '{1'b1, mode_reg, pcf_pkg::ST_BUFFERING};
                        moves[1]  = '{1'b1, pcf_pkg::ST_BUFFERING, pcf_pkg::ST_READY};
                        moves[2]  = '{1'b1, pcf_pkg::ST_READY, pcf_pkg::ST_PLAYING};
                        mode_next = pcf_pkg::ST_PLAYING;
                        pos_next  = in_target_reg;
                    end
                end
                pcf_pkg::REQ_STOP: begin
                    if (mode_reg == pcf_pkg::ST_IDLE) begin
                        ev_inc[pcf_pkg::CNT_ILLEGAL] = 1'b1;
                        moves[0] = '{1'b1, mode_reg, pcf_pkg::ST_STOPPING};
                        acc_next = 1'b0;
                    end else begin
                        lat_en    = 1'b1;
                        lat_limit = cfg.stop_limit;
                        moves[0]  = '{(mode_reg != pcf_pkg::ST_STOPPING), mode_reg,
                                      pcf_pkg::ST_STOPPING};
                        moves[1]  = '{1'b1, pcf_pkg::ST_STOPPING, pcf_pkg::ST_IDLE};
                        mode_next = pcf_pkg::ST_IDLE;
                    end
                end
                pcf_pkg::REQ_RECOVER: begin
                    moves[0] = '{1'b1, mode_reg, pcf_pkg::ST_BUFFERING};
                    if (mode_reg != pcf_pkg::ST_ERROR) begin
                        ev_inc[pcf_pkg::CNT_ILLEGAL] = 1'b1;
                        acc_next = 1'b0;
                    end else begin
                        ev_inc[pcf_pkg::CNT_RECOVER] = 1'b1;
                        mode_next = pcf_pkg::ST_BUFFERING;
                    end
                end
                pcf_pkg::REQ_DEPTH: begin
                    if (in_cap_reg != 16'd0) begin
                        if ((mode_reg == pcf_pkg::ST_BUFFERING)
                            && (in_depth_reg >= cfg.readiness)) begin
                            moves[0]  = '{1'b1, pcf_pkg::ST_BUFFERING, pcf_pkg::ST_READY};
                            moves[1]  = '{1'b1, pcf_pkg::ST_READY, pcf_pkg::ST_PLAYING};
                            mode_next = pcf_pkg::ST_PLAYING;
                        end else if ((mode_reg == pcf_pkg::ST_PLAYING)
                                     && (in_depth_reg == 16'd0)) begin
                            moves[0]  = '{1'b1, pcf_pkg::ST_PLAYING, pcf_pkg::ST_BUFFERING};
                            mode_next = pcf_pkg::ST_BUFFERING;
                        end
                    end
                end
                pcf_pkg::REQ_UNDERRUN: begin
                    if (mode_reg == pcf_pkg::ST_PLAYING) begin
                        moves[0]  = '{1'b1, pcf_pkg::ST_PLAYING, pcf_pkg::ST_BUFFERING};
                        mode_next = pcf_pkg::ST_BUFFERING;
                    end
                end
                pcf_pkg::REQ_OVERRUN,
                pcf_pkg::REQ_OVERFLOW: begin
                    ev_inc[pcf_pkg::CNT_OVERFLOW] = 1'b1;
                end
                pcf_pkg::REQ_CLEARED: begin
                    if (mode_reg == pcf_pkg::ST_BUFFERING) begin
                        moves[0]  = '{1'b1, pcf_pkg::ST_BUFFERING, pcf_pkg::ST_READY};
                        moves[1]  = '{1'b1, pcf_pkg::ST_READY, pcf_pkg::ST_PLAYING};
                        mode_next = pcf_pkg::ST_PLAYING;
                    end
                end
                pcf_pkg::REQ_TIMEOUT: begin
                    ev_inc[pcf_pkg::CNT_TIMEOUT] = 1'b1;
                    moves[0]  = '{(mode_reg != pcf_pkg::ST_ERROR), mode_reg,
                                  pcf_pkg::ST_ERROR};
                    mode_next = pcf_pkg::ST_ERROR;
                end
                pcf_pkg::REQ_QUERY: begin
                    if ((in_qf_reg < 3'(pcf_pkg::STATE_COUNT))
                        && (in_qt_reg < 3'(pcf_pkg::STATE_COUNT))) begin
                        tcount_next = query_view;
                    end
                end
                default: ;
            endcase
        end

        lat_over = lat_en && (in_eff_reg > in_req_reg)
                   && (lat_diff > {{(TW-32){1'b0}}, lat_limit});
        ev_inc[pcf_pkg::CNT_LATENCY] = lat_over;

        // drop all updates unless the beat actually advances
        if (!fire) begin
            moves     = '0;
            ev_inc    = '0;
            mode_next = mode_reg;
            pos_next  = pos_reg;
        end
    end

    pcf_trans_matrix #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_matrix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .moves      (moves),
        .query_from (in_qf_reg),
        .query_to   (in_qt_reg),
        .query_view (query_view)
    );

    genvar ge;
    generate
        for (ge = 0; ge < pcf_pkg::EVENT_COUNT; ge++) begin : g_event
            pcf_sat_counter #(
                .WIDTH (COUNT_WIDTH)
            ) u_event (
                .aclk    (aclk),
                .aresetn (aresetn),
                .inc     (ev_inc[ge]),
                .view    (ev_view[ge])
            );
        end
    endgenerate

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= pcf_pkg::ST_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            acc_reg    <= acc_next;
            tcount_reg <= tcount_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, tcount_reg, pos_reg,
                       ev_view[pcf_pkg::CNT_LATESEEK], ev_view[pcf_pkg::CNT_RECOVER],
                       ev_view[pcf_pkg::CNT_OVERFLOW], ev_view[pcf_pkg::CNT_TIMEOUT],
                       ev_view[pcf_pkg::CNT_LATENCY], ev_view[pcf_pkg::CNT_ILLEGAL],
                       mode_reg, acc_reg};

`ifndef NO_ASSERTIONS
    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(mode_reg) && $stable(pos_reg)))
        else $error("state changed while a result beat was stalled");

    a_stop_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (req == pcf_pkg::REQ_STOP) && !in_repeat_reg
         && (mode_reg != pcf_pkg::ST_IDLE)) |=> (mode_reg == pcf_pkg::ST_IDLE))
        else $error("accepted stop did not end in idle");

    a_reject_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !acc_next) |=> ($stable(mode_reg) && $stable(pos_reg)))
        else $error("rejected command changed play state or position");
`endif

endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for playout_control_fsm
// Drives command and event beats over the input stream and programs the
// latency limits and readiness threshold over APB. A scoreboard class keeps
// its own copy of the play state, position, counters and state-change
// matrix, predicts every result beat and compares it whole. The run opens
// with a directed sequence, then runs several register settings with random,
// mostly well-formed commands, random gaps on either side in most of them,
// one long receiver hold-off that backs up the input and closing seeks.
// ----------------------------------------------------------------------------
module tb;
    import pcf_pkg::*;

    localparam logic [61:0] TIME_MAX        = '1;
    localparam logic [2:0]  NO_STATE        = 3'd7;
    localparam logic [3:0]  REQ_SPARE_FIRST = 4'd13;
    localparam logic [3:0]  REQ_SPARE_LAST  = 4'd15;
    localparam int          HOLD_CYCLES     = 400;
    localparam int          STALL_LIMIT     = 3000;
    localparam int          PHASE_ITEMS     = 305;

    typedef struct packed {
        logic [3:0]  kind;
        logic        dup;
        logic [61:0] t_req;
        logic [61:0] t_eff;
        logic [61:0] target;
        logic [15:0] depth;
        logic [15:0] cap;
        logic [2:0]  q_from;
        logic [2:0]  q_to;
    } play_request_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  state;
        logic [31:0] illegal;
        logic [31:0] slow;
        logic [31:0] timeouts;
        logic [31:0] overflows;
        logic [31:0] recoveries;
        logic [31:0] late_seeks;
        logic [61:0] position;
        logic [31:0] cell_count;
        logic [5:0]  pad;
    } play_result_t;

    class playout_scoreboard;
        state_t       mode = ST_IDLE;
        logic [61:0]  position = '0;
        logic [31:0]  pause_lim = LIMIT_RESET, resume_lim = LIMIT_RESET;
        logic [31:0]  seek_lim = LIMIT_RESET, stop_lim = LIMIT_RESET;
        logic [15:0]  readiness = READINESS_RESET;
        logic [31:0]  n_illegal = '0, n_slow = '0, n_timeout = '0;
        logic [31:0]  n_overflow = '0, n_recover = '0, n_late_seek = '0;
        logic [31:0]  moves [STATE_COUNT][STATE_COUNT];
        play_result_t pending_results[$];
        int           requests_seen = 0, rejected_seen = 0, dups_seen = 0;
        int           results_checked = 0, mismatches = 0, reg_writes = 0;

        function new();
            foreach (moves[i, j]) moves[i][j] = '0;
        endfunction

        function logic [31:0] bump(logic [31:0] v);
            return (v == '1) ? v : v + 32'd1;
        endfunction

        function void step_to(state_t to);
            if (mode != to) begin
                moves[mode][to] = bump(moves[mode][to]);
                mode = to;
            end
        endfunction

        function logic refuse(state_t to);
            n_illegal = bump(n_illegal);
            moves[mode][to] = bump(moves[mode][to]);
            return 1'b0;
        endfunction

        function void time_check(play_request_t r, logic [31:0] lim);
            if (r.t_eff > r.t_req && (r.t_eff - r.t_req) > 62'(lim))
                n_slow = bump(n_slow);
        endfunction

        function logic [31:0] limit_for(logic [3:0] kind);
            case (kind)
                REQ_PAUSE:  return pause_lim;
                REQ_RESUME: return resume_lim;
                REQ_SEEK:   return seek_lim;
                REQ_STOP:   return stop_lim;
                default:    return '0;
            endcase
        endfunction

        function void set_register(reg_idx_t idx, logic [31:0] v);
            reg_writes++;
            case (idx)
                REG_PAUSE_LIMIT:  pause_lim = v;
                REG_RESUME_LIMIT: resume_lim = v;
                REG_SEEK_LIMIT:   seek_lim = v;
                REG_STOP_LIMIT:   stop_lim = v;
                REG_READINESS:    readiness = v[15:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] register_value(reg_idx_t idx);
            case (idx)
                REG_PAUSE_LIMIT:  return pause_lim;
                REG_RESUME_LIMIT: return resume_lim;
                REG_SEEK_LIMIT:   return seek_lim;
                REG_STOP_LIMIT:   return stop_lim;
                default:          return {16'd0, readiness};
            endcase
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function string describe(play_result_t v);
            return $sformatf({"acc=%0d st=%0d ill=%0d slow=%0d tmo=%0d ovf=%0d rec=%0d",
                              " lsk=%0d pos=%0d cnt=%0d pad=%0d"},
                             v.accepted, v.state, v.illegal, v.slow, v.timeouts,
                             v.overflows, v.recoveries, v.late_seeks, v.position,
                             v.cell_count, v.pad);
        endfunction

        function void note_request(play_request_t r);
            play_result_t e;
            logic         ok;
            logic [31:0]  hit_count;
            ok = 1'b1;
            hit_count = '0;
            requests_seen++;
            if (r.kind <= REQ_RECOVER && r.dup) begin
                dups_seen++;
            end else begin
                case (r.kind)
                    REQ_BEGIN:
                        if (mode != ST_IDLE) ok = refuse(ST_BUFFERING);
                        else step_to(ST_BUFFERING);
                    REQ_PAUSE:
                        if (mode != ST_PLAYING) begin
                            ok = refuse(ST_PAUSED);
                        end else begin
                            time_check(r, pause_lim);
                            step_to(ST_PAUSED);
                        end
                    REQ_RESUME:
                        if (mode != ST_PAUSED) begin
                            ok = refuse(ST_PLAYING);
                        end else begin
                            time_check(r, resume_lim);
                            step_to(ST_PLAYING);
                        end
                    REQ_SEEK:
                        if (r.target < position) begin
                            n_late_seek = bump(n_late_seek);
                            ok = 1'b0;
                        end else if (mode != ST_PLAYING && mode != ST_PAUSED) begin
                            ok = refuse(ST_BUFFERING);
                        end else begin
                            time_check(r, seek_lim);
                            step_to(ST_BUFFERING);
                            step_to(ST_READY);
                            step_to(ST_PLAYING);
                            position = r.target;
                        end
                    REQ_STOP:
                        if (mode == ST_IDLE) begin
                            ok = refuse(ST_STOPPING);
                        end else begin
                            time_check(r, stop_lim);
                            step_to(ST_STOPPING);
                            step_to(ST_IDLE);
                        end
                    REQ_RECOVER:
                        if (mode != ST_ERROR) begin
                            ok = refuse(ST_BUFFERING);
                        end else begin
                            step_to(ST_BUFFERING);
                            n_recover = bump(n_recover);
                        end
                    REQ_DEPTH:
                        if (r.cap != '0) begin
                            if (mode == ST_BUFFERING && r.depth >= readiness) begin
                                step_to(ST_READY);
                                step_to(ST_PLAYING);
                            end else if (mode == ST_PLAYING && r.depth == '0) begin
                                step_to(ST_BUFFERING);
                            end
                        end
                    REQ_UNDERRUN:
                        if (mode == ST_PLAYING) step_to(ST_BUFFERING);
                    REQ_OVERRUN, REQ_OVERFLOW:
                        n_overflow = bump(n_overflow);
                    REQ_CLEARED:
                        if (mode == ST_BUFFERING) begin
                            step_to(ST_READY);
                            step_to(ST_PLAYING);
                        end
                    REQ_TIMEOUT: begin
                        n_timeout = bump(n_timeout);
                        step_to(ST_ERROR);
                    end
                    REQ_QUERY:
                        if (r.q_from != NO_STATE && r.q_to != NO_STATE)
                            hit_count = moves[r.q_from][r.q_to];
                    default: ;
                endcase
            end
            if (!ok) rejected_seen++;
            e.accepted   = ok;
            e.state      = mode;
            e.illegal    = n_illegal;
            e.slow       = n_slow;
            e.timeouts   = n_timeout;
            e.overflows  = n_overflow;
            e.recoveries = n_recover;
            e.late_seeks = n_late_seek;
            e.position   = position;
            e.cell_count = hit_count;
            e.pad        = '0;
            pending_results = {pending_results, e};
        endfunction

        function void check_result(play_result_t got);
            play_result_t want;
            if (pending_results.size() == 0) begin
                note_mismatch({"MISMATCH unexpected result beat: ", describe(got)});
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (got !== want)
                note_mismatch({"MISMATCH beat ", $sformatf("%0d", results_checked),
                               "\n  expected ", describe(want), "\n  actual   ", describe(got)});
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic [223:0]          s_tdata;
    logic [4:0]            s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [295:0]          m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    playout_scoreboard board;
    bit                src_gaps;
    bit                sink_gaps;
    bit                hold_req;
    int                holds_done;
    int                stall_cycles;

    playout_control_fsm DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [61:0] rand62();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[61:0];
    endfunction

    function automatic req_t pick4(req_t a, req_t b, req_t c, req_t d);
        case ($urandom_range(0, 3))
            0:       return a;
            1:       return b;
            2:       return c;
            default: return d;
        endcase
    endfunction

    function automatic play_request_t plain(logic [3:0] kind);
        play_request_t r;
        r.kind   = kind;
        r.dup    = 1'b0;
        r.t_req  = rand62();
        r.t_eff  = rand62();
        r.target = rand62();
        r.depth  = 16'($urandom);
        r.cap    = 16'($urandom);
        r.q_from = 3'($urandom);
        r.q_to   = 3'($urandom);
        return r;
    endfunction

    // mostly commands that are legal in the predicted state, some noise
    function automatic play_request_t next_request();
        play_request_t r;
        logic [31:0]   lim;
        r = plain(REQ_QUERY);
        r.dup = ($urandom_range(0, 11) == 0);
        if ($urandom_range(0, 4) == 0) begin
            r.kind = 4'($urandom_range(0, 15));
        end else begin
            case (board.mode)
                ST_IDLE:      r.kind = pick4(REQ_BEGIN, REQ_BEGIN, REQ_BEGIN, REQ_QUERY);
                ST_BUFFERING: r.kind = pick4(REQ_DEPTH, REQ_DEPTH, REQ_CLEARED, REQ_STOP);
                ST_PLAYING:   r.kind = pick4(REQ_PAUSE, REQ_SEEK, REQ_DEPTH,
                                             pick4(REQ_UNDERRUN, REQ_STOP, REQ_TIMEOUT,
                                                   REQ_OVERRUN));
                ST_PAUSED:    r.kind = pick4(REQ_RESUME, REQ_SEEK, REQ_STOP, REQ_QUERY);
                ST_ERROR:     r.kind = pick4(REQ_RECOVER, REQ_RECOVER, REQ_STOP, REQ_QUERY);
                default:      r.kind = REQ_QUERY;
            endcase
        end
        if (r.kind == REQ_DEPTH) begin
            if ($urandom_range(0, 7) == 0) r.cap = '0;
            case ($urandom_range(0, 3))
                0:       r.depth = '0;
                1:       r.depth = board.readiness;
                2:       r.depth = board.readiness - 16'd1;
                default: ;
            endcase
        end
        if (r.kind == REQ_SEEK) begin
            if (board.position != '0 && $urandom_range(0, 7) == 0)
                r.target = rand62() % board.position;
            else if ($urandom_range(0, 7) == 0)
                r.target = board.position;
            else
                r.target = board.position + 62'($urandom_range(1, 100000));
        end
        if (r.kind inside {REQ_PAUSE, REQ_RESUME, REQ_SEEK, REQ_STOP}) begin
            lim = board.limit_for(r.kind);
            case ($urandom_range(0, 4))
                0:       r.t_eff = r.t_req + 62'(lim);
                1:       r.t_eff = r.t_req + 62'(lim) + 62'd1;
                2:       r.t_eff = r.t_req - 62'($urandom_range(1, 1000));
                3:       r.t_eff = r.t_req + 62'($urandom);
                default: ;
            endcase
        end
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic push_request(input play_request_t r);
        int gap;
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {r.q_to, r.q_from, r.cap, r.depth, r.target, r.t_eff, r.t_req};
        s_tuser  <= {r.dup, r.kind};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_request(r);
        @(negedge aclk);
    endtask

    task automatic reg_read(input reg_idx_t idx);
        logic [31:0] want;
        want = board.register_value(idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want)
            board.note_mismatch($sformatf("MISMATCH register %0d read: expected %0d actual %0d",
                                          idx, want, prdata));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.set_register(idx, v);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        reg_read(idx);
    endtask

    task automatic configure(input logic [31:0] p, input logic [31:0] rs,
                             input logic [31:0] sk, input logic [31:0] st,
                             input logic [15:0] rf);
        reg_write(REG_PAUSE_LIMIT, p);
        reg_write(REG_RESUME_LIMIT, rs);
        reg_write(REG_SEEK_LIMIT, sk);
        reg_write(REG_STOP_LIMIT, st);
        reg_write(REG_READINESS, {16'd0, rf});
    endtask

    task automatic run_phase(input int count, input bit src_on, input bit sink_on,
                             input int hold_at);
        src_gaps  = src_on;
        sink_gaps = sink_on;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) hold_req = 1'b1;
            push_request(next_request());
        end
    endtask

    // hold until every expected beat is back, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin : sink_ctl
        int n;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
                holds_done++;
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 11);
                m_tready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        play_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.accepted   = m_tdata[0];
            got.state      = m_tdata[3:1];
            got.illegal    = m_tdata[35:4];
            got.slow       = m_tdata[67:36];
            got.timeouts   = m_tdata[99:68];
            got.overflows  = m_tdata[131:100];
            got.recoveries = m_tdata[163:132];
            got.late_seeks = m_tdata[195:164];
            got.position   = m_tdata[257:196];
            got.cell_count = m_tdata[289:258];
            got.pad        = m_tdata[295:290];
            board.check_result(got);
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", stall_cycles);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : run
        play_request_t r;
        board        = new();
        src_gaps     = 1'b1;
        sink_gaps    = 1'b1;
        hold_req     = 1'b0;
        holds_done   = 0;
        stall_cycles = 0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        reg_read(REG_PAUSE_LIMIT);
        reg_read(REG_RESUME_LIMIT);
        reg_read(REG_SEEK_LIMIT);
        reg_read(REG_STOP_LIMIT);
        reg_read(REG_READINESS);

        // directed pass at reset limits
        r = plain(REQ_QUERY);
        r.q_from = ST_IDLE;
        r.q_to = ST_BUFFERING;
        push_request(r);
        push_request(plain(REQ_STOP));
        push_request(plain(REQ_PAUSE));
        r = plain(REQ_SEEK);
        r.target = '0;
        push_request(r);
        r = plain(REQ_BEGIN);
        r.dup = 1'b1;
        push_request(r);
        push_request(plain(REQ_BEGIN));
        push_request(plain(REQ_BEGIN));
        r = plain(REQ_DEPTH);
        r.cap = '0;
        r.depth = '1;
        push_request(r);
        r.cap = '1;
        r.depth = 16'd2;
        push_request(r);
        r.cap = 16'd1;
        r.depth = 16'd3;
        push_request(r);
        r = plain(REQ_PAUSE);
        r.t_req = TIME_MAX - 62'd600000;
        r.t_eff = r.t_req + 62'd500001;
        push_request(r);
        r = plain(REQ_RESUME);
        r.t_req = '0;
        r.t_eff = 62'd500000;
        push_request(r);
        r = plain(REQ_SEEK);
        r.t_req = TIME_MAX;
        r.t_eff = '0;
        r.target = 62'd1000;
        push_request(r);
        r.target = 62'd10;
        push_request(r);
        push_request(plain(REQ_UNDERRUN));
        push_request(plain(REQ_CLEARED));
        r = plain(REQ_DEPTH);
        r.cap = 16'd5;
        r.depth = '0;
        push_request(r);
        r = plain(REQ_OVERRUN);
        r.dup = 1'b1;
        push_request(r);
        push_request(plain(REQ_OVERFLOW));
        push_request(plain(REQ_TIMEOUT));
        push_request(plain(REQ_RESUME));
        push_request(plain(REQ_RECOVER));
        r = plain(REQ_STOP);
        r.t_req = '0;
        r.t_eff = TIME_MAX;
        push_request(r);
        r = plain(REQ_QUERY);
        r.q_from = NO_STATE;
        r.q_to = ST_IDLE;
        push_request(r);
        r.q_from = ST_BUFFERING;
        r.q_to = ST_BUFFERING;
        push_request(r);
        r = plain(REQ_SPARE_FIRST);
        r.dup = 1'b1;
        push_request(r);
        push_request(plain(REQ_SPARE_LAST));
        drain();

        configure('0, '0, '0, '0, '0);
        run_phase(PHASE_ITEMS, 1'b1, 1'b1, -1);
        drain();
        configure('1, '1, '1, '1, '1);
        run_phase(PHASE_ITEMS, 1'b1, 1'b0, -1);
        drain();
        configure($urandom_range(0, 2000), $urandom_range(0, 2000), $urandom_range(0, 2000),
                  $urandom_range(0, 2000), 16'($urandom_range(1, 6)));
        run_phase(PHASE_ITEMS, 1'b0, 1'b1, -1);
        drain();
        configure($urandom, $urandom, $urandom, $urandom, 16'd1);
        run_phase(PHASE_ITEMS, 1'b1, 1'b1, -1);
        drain();
        configure(LIMIT_RESET, $urandom_range(0, 1000000), LIMIT_RESET,
                  $urandom_range(0, 1000000), READINESS_RESET);
        run_phase(PHASE_ITEMS, 1'b1, 1'b1, 100);
        drain();
        configure($urandom_range(0, 100000), $urandom_range(0, 100000),
                  $urandom_range(0, 100000), $urandom_range(0, 100000),
                  16'($urandom_range(0, 4)));
        run_phase(PHASE_ITEMS, 1'b0, 1'b0, -1);

        // walk to playing, then seek to the top of the time range and behind it
        push_request(plain(REQ_TIMEOUT));
        push_request(plain(REQ_RECOVER));
        push_request(plain(REQ_CLEARED));
        r = plain(REQ_SEEK);
        r.target = TIME_MAX;
        push_request(r);
        r.target = TIME_MAX - 62'd1;
        push_request(r);
        drain();

        $display("covered %0d command beats (%0d rejected, %0d duplicates), %0d register writes",
                 board.requests_seen, board.rejected_seen, board.dups_seen, board.reg_writes);
        $display("checked %0d result beats across %0d long hold-offs, %0d mismatches",
                 board.results_checked, holds_done, board.mismatches);
        if (board.mismatches == 0 && board.pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
